@@ rtl/ttc_pkg.sv @@
// Package for the tempo transport clock: widths, limits, command codes,
// controller states and the control/status structs. No dependencies.
package ttc_pkg;

    localparam int MEASURE_BITS    = 12;
    localparam int NAV_MEASURE_MAX = 125;

    localparam int CMD_W      = 4;
    localparam int TEMPO_W    = 9;
    localparam int TPQ_W      = 10;
    localparam int BPM_W      = 5;
    localparam int POS_W      = 26;
    localparam int MEAS_OUT_W = 12;
    localparam int MTICK_W    = 14;
    localparam int DELTA_W    = 19;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int TPQ_MIN     = 24;
    localparam int TPQ_MAX     = 960;
    localparam int TPQ_RESET   = 480;
    localparam int BPM_MIN     = 1;
    localparam int BPM_MAX     = 16;
    localparam int BPM_RESET   = 4;
    localparam int TEMPO_MIN   = 30;
    localparam int TEMPO_MAX   = 300;
    localparam int TEMPO_RESET = 120;

    localparam logic [MEASURE_BITS-1:0] MEAS_LIMIT = '1;
    localparam logic [MEASURE_BITS-1:0] NAV_MAX    = MEASURE_BITS'(NAV_MEASURE_MAX);
    localparam int PM_W = MEASURE_BITS + MTICK_W;

    // tick/3600 = ((tick >> 4) * floor(2^30 / 225)) >> 30, plus one fix-up step
    localparam int FRAC_UNITS  = 3600;
    localparam int FRAC_SHIFT  = 4;
    localparam int FRAC_ODD    = 225;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_MUL   = 4772185;
    localparam int XQ_W        = POS_W - FRAC_SHIFT;
    localparam int PROD_W      = 45;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;

    // remainder by restoring subtraction of len << k, k = RED_STEPS-1 .. 0
    localparam int RED_STEPS  = 10;
    localparam int RED_CNT_W  = 4;
    localparam int RED_EXT_W  = POS_W + RED_STEPS;

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME  = 4'd0,
        CMD_FASTER = 4'd1,
        CMD_SLOWER = 4'd2,
        CMD_REPEAT = 4'd3,
        CMD_NEXT   = 4'd4,
        CMD_PREV   = 4'd5,
        CMD_FIRST  = 4'd6,
        CMD_END    = 4'd7,
        CMD_STOP   = 4'd8,
        CMD_PLAY   = 4'd9,
        CMD_LOAD   = 4'd10
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TPQ = 1'b0,
        CFG_BPM = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EXEC,
        ST_REDUCE,
        ST_ADVANCE,
        ST_POS_MUL,
        ST_POS_EST,
        ST_POS_FIX
    } ctrl_state_t;

    typedef struct packed {
        logic                 load_in;
        logic                 exec;
        logic                 reduce;
        logic [RED_CNT_W-1:0] red_shift;
        logic                 advance;
        logic                 pos_mul;
        logic                 pos_est;
        logic                 pos_fix;
    } dp_ctrl_t;

    typedef struct packed {
        logic is_frame;
        logic playing;
        logic need_reduce;
    } dp_stat_t;

    typedef struct packed {
        logic                  position_valid;
        logic [POS_W-1:0]      position_ticks;
        logic [POS_W-1:0]      prev_position_ticks;
        logic [MEAS_OUT_W-1:0] measure_number;
        logic [TEMPO_W-1:0]    tempo_bpm;
        logic                  playing;
        logic                  repeat_on;
        logic                  moved_back;
    } res_t;

endpackage

@@ rtl/ttc_if.sv @@
// Valid/ready channel interfaces for commands and results.
// Depends on ttc_pkg.
interface ttc_cmd_if;
    import ttc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [TEMPO_W-1:0] tempo_value;

    modport source (output valid, output cmd, output tempo_value, input ready);
    modport sink (input valid, input cmd, input tempo_value, output ready);
endinterface

interface ttc_res_if;
    import ttc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  position_valid;
    logic [POS_W-1:0]      position_ticks;
    logic [POS_W-1:0]      prev_position_ticks;
    logic [MEAS_OUT_W-1:0] measure_number;
    logic [TEMPO_W-1:0]    tempo_bpm;
    logic                  playing;
    logic                  repeat_on;
    logic                  moved_back;

    modport source (
        output valid, output position_valid, output position_ticks,
        output prev_position_ticks, output measure_number, output tempo_bpm,
        output playing, output repeat_on, output moved_back, input ready
    );
    modport sink (
        input valid, input position_valid, input position_ticks,
        input prev_position_ticks, input measure_number, input tempo_bpm,
        input playing, input repeat_on, input moved_back, output ready
    );
endinterface

@@ rtl/ttc_ctrl.sv @@
// Transport controller: sequences command execution, remainder steps and
// position arithmetic, and owns the result valid flag. Depends on ttc_pkg.
module ttc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ttc_pkg::dp_stat_t stat,
    output ttc_pkg::dp_ctrl_t ctrl
);
    import ttc_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [RED_CNT_W-1:0] red_cnt_reg, red_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            red_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            red_cnt_reg   <= red_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:    state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (stat.is_frame && stat.playing)
                    state_next = stat.need_reduce ? ST_REDUCE : ST_ADVANCE;
                else
                    state_next = ST_POS_MUL;
            end
            ST_REDUCE:
            begin
                if (red_cnt_reg == '0)
                    state_next = ST_ADVANCE;
            end
            ST_ADVANCE: state_next = ST_POS_MUL;
            ST_POS_MUL: state_next = ST_POS_EST;
            ST_POS_EST: state_next = ST_POS_FIX;
            ST_POS_FIX:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        in_ready       = 1'b0;
        red_cnt_next   = red_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.red_shift = red_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.load_in = in_valid;
            end
            ST_PREP:    ;
            ST_EXEC:
            begin
                ctrl.exec    = 1'b1;
                red_cnt_next = RED_CNT_W'(RED_STEPS - 1);
            end
            ST_REDUCE:
            begin
                ctrl.reduce  = 1'b1;
                red_cnt_next = red_cnt_reg - 1'b1;
            end
            ST_ADVANCE: ctrl.advance = 1'b1;
            ST_POS_MUL: ctrl.pos_mul = 1'b1;
            ST_POS_EST: ctrl.pos_est = 1'b1;
            ST_POS_FIX:
            begin
                ctrl.pos_fix = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:    ;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start processing");

    a_reduce_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE && red_cnt_reg == '0) |=> (state_reg == ST_ADVANCE))
        else $error("remainder loop did not terminate");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POS_FIX && out_valid_reg && !out_ready)
        |=> (state_reg == ST_POS_FIX && out_valid_reg))
        else $error("result overwritten while pending");
`endif

endmodule

@@ rtl/ttc_datapath.sv @@
// Transport datapath: configuration, transport state, tick accumulator,
// remainder unit and position arithmetic. Depends on ttc_pkg.
module ttc_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [ttc_pkg::CMD_W-1:0]        in_cmd,
    input  logic [ttc_pkg::TEMPO_W-1:0]      in_tempo,
    input  ttc_pkg::dp_ctrl_t                ctrl,
    output ttc_pkg::dp_stat_t                stat,
    output ttc_pkg::res_t                    res
);
    import ttc_pkg::*;

    logic [TPQ_W-1:0]        tpq_reg, tpq_c;
    logic [BPM_W-1:0]        bpm_reg, bpm_c;
    logic [MTICK_W-1:0]      mticks_reg;
    logic [POS_W-1:0]        len_reg;
    logic [DELTA_W-1:0]      delta_reg;

    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [TEMPO_W-1:0]      tv_reg, tv_next;
    logic [POS_W-1:0]        tick_reg, tick_next;
    logic [POS_W-1:0]        prev_reg, prev_next;
    logic [MEASURE_BITS-1:0] mc_reg, mc_next;
    logic [TEMPO_W-1:0]      tempo_reg, tempo_next;
    logic                    play_reg, play_next;
    logic                    repeat_reg, repeat_next;
    logic                    valid_reg, valid_next;
    logic                    back_reg, back_next;

    logic [RED_EXT_W-1:0]    len_sh;
    logic [POS_W:0]          adv_sum;

    logic [XQ_W-1:0]         xa, xb;
    logic [PROD_W-1:0]       prod_a_reg, prod_b_reg;
    logic [PM_W-1:0]         prod_m_reg;
    logic [Q_W-1:0]          q0_a_reg, q0_b_reg;
    logic [XQ_W-1:0]         qm_a_reg, qm_b_reg;
    logic [XQ_W-1:0]         rem_a, rem_b;
    logic [Q_W-1:0]          q_a, q_b;
    res_t                    res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg <= TPQ_W'(TPQ_RESET);
            bpm_reg <= BPM_W'(BPM_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TPQ: tpq_reg <= cfg_data[TPQ_W-1:0];
                CFG_BPM: bpm_reg <= cfg_data[BPM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (tpq_reg < TPQ_W'(TPQ_MIN))
            tpq_c = TPQ_W'(TPQ_MIN);
        else if (tpq_reg > TPQ_W'(TPQ_MAX))
            tpq_c = TPQ_W'(TPQ_MAX);
        else
            tpq_c = tpq_reg;
        if (bpm_reg < BPM_W'(BPM_MIN))
            bpm_c = BPM_W'(BPM_MIN);
        else if (bpm_reg > BPM_W'(BPM_MAX))
            bpm_c = BPM_W'(BPM_MAX);
        else
            bpm_c = bpm_reg;
    end

    // measure length and per-frame step, registered from config/tempo (length via mticks_reg, then len_reg)
    always_ff @(posedge clk)
    begin
        mticks_reg <= MTICK_W'(tpq_c) * MTICK_W'(bpm_c);
        len_reg    <= POS_W'(mticks_reg) * POS_W'(FRAC_UNITS);
        delta_reg  <= DELTA_W'(tempo_reg) * DELTA_W'(tpq_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg    <= '0;
            tv_reg     <= '0;
            tick_reg   <= '0;
            prev_reg   <= '0;
            mc_reg     <= MEASURE_BITS'(1);
            tempo_reg  <= TEMPO_W'(TEMPO_RESET);
            play_reg   <= 1'b0;
            repeat_reg <= 1'b0;
            valid_reg  <= 1'b0;
            back_reg   <= 1'b0;
        end
        else
        begin
            cmd_reg    <= cmd_next;
            tv_reg     <= tv_next;
            tick_reg   <= tick_next;
            prev_reg   <= prev_next;
            mc_reg     <= mc_next;
            tempo_reg  <= tempo_next;
            play_reg   <= play_next;
            repeat_reg <= repeat_next;
            valid_reg  <= valid_next;
            back_reg   <= back_next;
        end
    end

    assign len_sh  = RED_EXT_W'(len_reg) << ctrl.red_shift;
    assign adv_sum = (POS_W + 1)'(tick_reg) + (POS_W + 1)'(delta_reg);

    always_comb
    begin
        cmd_next    = cmd_reg;
        tv_next     = tv_reg;
        tick_next   = tick_reg;
        prev_next   = prev_reg;
        mc_next     = mc_reg;
        tempo_next  = tempo_reg;
        play_next   = play_reg;
        repeat_next = repeat_reg;
        valid_next  = valid_reg;
        back_next   = back_reg;

        if (ctrl.load_in)
        begin
            cmd_next   = in_cmd;
            tv_next    = in_tempo;
            valid_next = 1'b0;
            back_next  = 1'b0;
        end

        if (ctrl.exec)
        begin
            case (cmd_reg)
                CMD_FASTER:
                begin
                    if (tempo_reg < TEMPO_W'(TEMPO_MAX))
                        tempo_next = tempo_reg + 1'b1;
                end
                CMD_SLOWER:
                begin
                    if (tempo_reg > TEMPO_W'(TEMPO_MIN))
                        tempo_next = tempo_reg - 1'b1;
                end
                CMD_REPEAT: repeat_next = !repeat_reg;
                CMD_NEXT:
                begin
                    if (mc_reg < NAV_MAX)
                        mc_next = mc_reg + 1'b1;
                end
                CMD_PREV:
                begin
                    if (mc_reg != '0)
                    begin
                        mc_next   = mc_reg - 1'b1;
                        back_next = 1'b1;
                    end
                end
                CMD_FIRST:
                begin
                    if (tick_reg != '0)
                        tick_next = '0;
                    else if (mc_reg != '0)
                    begin
                        mc_next   = mc_reg - 1'b1;
                        back_next = 1'b1;
                    end
                end
                CMD_END:
                begin
                    tick_next = '0;
                    if (mc_reg < NAV_MAX)
                        mc_next = mc_reg + 1'b1;
                end
                CMD_STOP:
                begin
                    mc_next   = MEASURE_BITS'(1);
                    tick_next = '0;
                    prev_next = '0;
                end
                CMD_PLAY:   play_next = !play_reg;
                CMD_LOAD:
                begin
                    if (tv_reg < TEMPO_W'(TEMPO_MIN))
                        tempo_next = TEMPO_W'(TEMPO_MIN);
                    else if (tv_reg > TEMPO_W'(TEMPO_MAX))
                        tempo_next = TEMPO_W'(TEMPO_MAX);
                    else
                        tempo_next = tv_reg;
                end
                default:    ;
            endcase
        end

        if (ctrl.reduce)
        begin
            if (RED_EXT_W'(tick_reg) >= len_sh)
                tick_next = tick_reg - len_sh[POS_W-1:0];
        end

        if (ctrl.advance)
        begin
            prev_next  = tick_reg;
            valid_next = 1'b1;
            if (adv_sum >= (POS_W + 1)'(len_reg))
            begin
                tick_next = POS_W'(adv_sum - (POS_W + 1)'(len_reg));
                if (!repeat_reg && mc_reg < MEAS_LIMIT)
                    mc_next = mc_reg + 1'b1;
            end
            else
                tick_next = adv_sum[POS_W-1:0];
        end
    end

    // position = tick/3600 + measure * ticks per measure
    assign xa = tick_reg[POS_W-1:FRAC_SHIFT];
    assign xb = prev_reg[POS_W-1:FRAC_SHIFT];

    always_ff @(posedge clk)
    begin
        if (ctrl.pos_mul)
        begin
            prod_a_reg <= PROD_W'(xa) * PROD_W'(RECIP_MUL);
            prod_b_reg <= PROD_W'(xb) * PROD_W'(RECIP_MUL);
            prod_m_reg <= PM_W'(mc_reg) * PM_W'(mticks_reg);
        end
        if (ctrl.pos_est)
        begin
            q0_a_reg <= prod_a_reg[PROD_W-1:RECIP_SHIFT];
            q0_b_reg <= prod_b_reg[PROD_W-1:RECIP_SHIFT];
            qm_a_reg <= XQ_W'(prod_a_reg[PROD_W-1:RECIP_SHIFT]) * XQ_W'(FRAC_ODD);
            qm_b_reg <= XQ_W'(prod_b_reg[PROD_W-1:RECIP_SHIFT]) * XQ_W'(FRAC_ODD);
        end
        if (ctrl.pos_fix)
            res_reg <= '{
                position_valid:      valid_reg,
                position_ticks:      POS_W'(prod_m_reg + PM_W'(q_a)),
                prev_position_ticks: POS_W'(prod_m_reg + PM_W'(q_b)),
                measure_number:      MEAS_OUT_W'(mc_reg),
                tempo_bpm:           tempo_reg,
                playing:             play_reg,
                repeat_on:           repeat_reg,
                moved_back:          back_reg
            };
    end

    // estimate is low by at most one
    assign rem_a = xa - qm_a_reg;
    assign rem_b = xb - qm_b_reg;
    assign q_a   = q0_a_reg + Q_W'(rem_a >= XQ_W'(FRAC_ODD));
    assign q_b   = q0_b_reg + Q_W'(rem_b >= XQ_W'(FRAC_ODD));

    assign stat.is_frame    = (cmd_reg == CMD_FRAME);
    assign stat.playing     = play_reg;
    assign stat.need_reduce = (tick_reg >= len_reg);
    assign res              = res_reg;

`ifndef ASSERT_OFF
    a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tempo_reg >= TEMPO_W'(TEMPO_MIN)) && (tempo_reg <= TEMPO_W'(TEMPO_MAX)))
        else $error("tempo out of range");

    a_back_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        back_reg |-> (cmd_reg == CMD_PREV || cmd_reg == CMD_FIRST))
        else $error("moved_back set by wrong command");

    a_valid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cmd_reg == CMD_FRAME && play_reg))
        else $error("position_valid without playing frame");
`endif

endmodule

@@ rtl/tempo_transport_clock.sv @@
// Sequence: a command beat is accepted in idle, passes prep and exec, for a
// playing frame the remainder loop (when the accumulator must be reduced after
// a shorter measure length has been configured) and advance, then multiply,
// estimate and fix-up; the result is registered once the output is free.
// A new command is taken only in idle, after the previous one's fix-up.
// Reset: async active low; measure 1, tempo 120, paused, repeat off.
module tempo_transport_clock (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0] cfg_data,
    ttc_cmd_if.sink                        command,
    ttc_res_if.source                      result
);
    import ttc_pkg::*;

    dp_ctrl_t dp_ctrl;
    dp_stat_t dp_stat;
    res_t     res;

    ttc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (command.valid),
        .in_ready  (command.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (dp_stat),
        .ctrl      (dp_ctrl)
    );

    ttc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (command.cmd),
        .in_tempo  (command.tempo_value),
        .ctrl      (dp_ctrl),
        .stat      (dp_stat),
        .res       (res)
    );

    assign result.position_valid      = res.position_valid;
    assign result.position_ticks      = res.position_ticks;
    assign result.prev_position_ticks = res.prev_position_ticks;
    assign result.measure_number      = res.measure_number;
    assign result.tempo_bpm           = res.tempo_bpm;
    assign result.playing             = res.playing;
    assign result.repeat_on           = res.repeat_on;
    assign result.moved_back          = res.moved_back;

endmodule
